// ----- rtl/frame_timer_handle_table_unit_assert.svh -----
// ----------------------------------------------------------------------------
// frame timer handle table assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef FRAME_TIMER_HANDLE_TABLE_UNIT_ASSERT_SVH
`define FRAME_TIMER_HANDLE_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FTHT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("frame timer handle table assertion failed");
`define FTHT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame timer handle table assertion failed");
`define FTHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame timer handle table assertion failed");
`else
`define FTHT_ASSERT(lbl, clk, rstn, prop)
`define FTHT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define FTHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/ftht_pkg.sv -----
// ----------------------------------------------------------------------------
// ftht_pkg
// shared constants, operation codes and controller interface types
// ----------------------------------------------------------------------------
package ftht_pkg;

  localparam int unsigned ENTRIES_DEF    = 64;
  localparam int unsigned FRAME_BITS_DEF = 16;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned FPS_W          = 8;
  localparam int unsigned OP_W           = 2;

  localparam logic [FPS_W-1:0] FPS_RESET = 8'd60;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

  typedef struct packed {
    logic cap_in;
    logic take_hint;
    logic scan_init;
    logic scan_step;
    logic take_scan;
    logic add_write;
    logic h2s_rd;
    logic drop_from_h2s;
    logic drop_from_tick;
    logic last_rd;
    logic move_write;
    logic drop_fin;
    logic lk_slot_rd;
    logic lk_cap;
    logic tick_rd;
    logic tick_upd;
    logic tick_adv;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic hint_free;
    logic scan_end;
    logic scan_free;
    logic hit;
    logic drop_move;
    logic tick_more;
    logic tick_drop;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/ftht_ram.sv -----
// ----------------------------------------------------------------------------
// ftht_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ftht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ftht_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftht_ctrl
// sequencer for add, remove, lookup and tick requests
// ----------------------------------------------------------------------------
module ftht_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [ftht_pkg::OP_W-1:0]  in_op_i,
  output logic                       in_ready_o,
  input  ftht_pkg::sts_t             sts_i,
  output ftht_pkg::cmd_t             cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ADD_CHK   = 4'd1;
  localparam logic [3:0] S_ADD_SCAN  = 4'd2;
  localparam logic [3:0] S_ADD_WR    = 4'd3;
  localparam logic [3:0] S_RM_CHK    = 4'd4;
  localparam logic [3:0] S_RM_SLOT   = 4'd5;
  localparam logic [3:0] S_DROP      = 4'd6;
  localparam logic [3:0] S_DROP_MV   = 4'd7;
  localparam logic [3:0] S_DROP_FIN  = 4'd8;
  localparam logic [3:0] S_LK_CHK    = 4'd9;
  localparam logic [3:0] S_LK_SLOT   = 4'd10;
  localparam logic [3:0] S_LK_DATA   = 4'd11;
  localparam logic [3:0] S_TICK_CHK  = 4'd12;
  localparam logic [3:0] S_TICK_EVAL = 4'd13;
  localparam logic [3:0] S_RESP      = 4'd14;

  logic [3:0]                state_q, state_d;
  logic [ftht_pkg::OP_W-1:0] op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          op_d         = in_op_i;
          case (in_op_i)
            ftht_pkg::OP_ADD:    state_d = S_ADD_CHK;
            ftht_pkg::OP_REMOVE: state_d = S_RM_CHK;
            ftht_pkg::OP_LOOKUP: state_d = S_LK_CHK;
            default:             state_d = S_TICK_CHK;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (!sts_i.add_ok) begin
          state_d = S_RESP;
        end else if (sts_i.hint_free) begin
          cmd_o.take_hint = 1'b1;
          state_d         = S_ADD_WR;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_ADD_SCAN;
        end
      end
      S_ADD_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_RESP;
        end else if (sts_i.scan_free) begin
          cmd_o.take_scan = 1'b1;
          state_d         = S_ADD_WR;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        state_d         = S_RESP;
      end
      S_RM_CHK: begin
        if (sts_i.hit) begin
          cmd_o.h2s_rd = 1'b1;
          state_d      = S_RM_SLOT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RM_SLOT: begin
        cmd_o.drop_from_h2s = 1'b1;
        state_d             = S_DROP;
      end
      S_DROP: begin
        if (sts_i.drop_move) begin
          cmd_o.last_rd = 1'b1;
          state_d       = S_DROP_MV;
        end else begin
          state_d = S_DROP_FIN;
        end
      end
      S_DROP_MV: begin
        cmd_o.move_write = 1'b1;
        state_d          = S_DROP_FIN;
      end
      S_DROP_FIN: begin
        cmd_o.drop_fin = 1'b1;
        if (op_q == ftht_pkg::OP_TICK) begin
          cmd_o.tick_adv = 1'b1;
          state_d        = S_TICK_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_LK_CHK: begin
        if (sts_i.hit) begin
          cmd_o.h2s_rd = 1'b1;
          state_d      = S_LK_SLOT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_LK_SLOT: begin
        cmd_o.lk_slot_rd = 1'b1;
        state_d          = S_LK_DATA;
      end
      S_LK_DATA: begin
        cmd_o.lk_cap = 1'b1;
        state_d      = S_RESP;
      end
      S_TICK_CHK: begin
        if (sts_i.tick_more) begin
          cmd_o.tick_rd = 1'b1;
          state_d       = S_TICK_EVAL;
        end else begin
          state_d = S_RESP;
        end
      end
      S_TICK_EVAL: begin
        if (sts_i.tick_drop) begin
          cmd_o.drop_from_tick = 1'b1;
          state_d              = S_DROP;
        end else begin
          cmd_o.tick_upd = 1'b1;
          cmd_o.tick_adv = 1'b1;
          state_d        = S_TICK_CHK;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= ftht_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ----- rtl/ftht_dp.sv -----
// ----------------------------------------------------------------------------
// ftht_dp
// handle map, slot store, counters and result register
// ----------------------------------------------------------------------------
module ftht_dp #(
  parameter int unsigned ENTRIES    = ftht_pkg::ENTRIES_DEF,
  parameter int unsigned FRAME_BITS = ftht_pkg::FRAME_BITS_DEF,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ftht_pkg::cmd_t                   cmd_i,
  output ftht_pkg::sts_t                   sts_o,
  input  logic                             cfg_wr_en_i,
  input  logic [ftht_pkg::FPS_W-1:0]       cfg_wr_data_i,
  input  logic [ftht_pkg::DUR_W-1:0]       in_duration_i,
  input  logic                             in_repeat_i,
  input  logic                             in_remove_i,
  input  logic [IW-1:0]                    in_handle_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [IW-1:0]                    out_new_handle_o,
  output logic [FRAME_BITS-1:0]            out_current_o,
  output logic [FRAME_BITS-1:0]            out_max_o,
  output logic                             out_found_o,
  output logic [IW-1:0]                    out_live_o
);

  localparam int unsigned CW   = IW + 1;
  localparam int unsigned FB   = FRAME_BITS;
  localparam int unsigned SW   = 2 * FB + 2 + IW;
  localparam int unsigned PW   = ftht_pkg::DUR_W + ftht_pkg::FPS_W;
  localparam int unsigned MW   = (FB > ftht_pkg::DUR_W) ? FB : ftht_pkg::DUR_W;
  localparam int unsigned O_MX = FB;
  localparam int unsigned O_RP = 2 * FB;
  localparam int unsigned O_AR = 2 * FB + 1;
  localparam int unsigned O_HD = 2 * FB + 2;

  logic [ftht_pkg::FPS_W-1:0] fps_q;
  logic [ftht_pkg::DUR_W-1:0] dur_q;
  logic [FB-1:0]              mx_q;
  logic                       rep_q, ar_q;
  logic [IW-1:0]              hdl_q;
  logic [IW-1:0]              count_q, hint_q, hsel_q, s_q, dh_q;
  logic [CW-1:0]              scan_q, idx_q;
  logic [ENTRIES-1:0]         hlive_q;
  logic [IW-1:0]              nh_q;
  logic [FB-1:0]              cur_q, max_q;
  logic                       fnd_q;
  logic                       ov_q;
  logic [IW-1:0]              onh_q, olive_q;
  logic [FB-1:0]              ocur_q, omax_q;
  logic                       ofnd_q;

  logic [PW-1:0]                 prod;
  logic [MW-1:0]                 sh_ext;
  logic [FB-1:0]                 mx_new;
  logic [IW-1:0]                 count_inc;
  logic                          h2s_we, h2s_re, slot_we, slot_re;
  logic [IW-1:0]                 h2s_waddr, h2s_wdata, h2s_rdata;
  logic [IW-1:0]                 slot_waddr, slot_raddr;
  logic [SW-1:0]                 slot_wdata, slot_rdata;
  logic [FB-1:0]                 rd_cur, rd_max;
  logic                          rd_rep, rd_ar, rd_done;
  logic [IW-1:0]                 rd_hdl;

  // max frames = duration * fps / 256, saturated
  assign prod   = PW'(in_duration_i) * PW'(fps_q);
  assign sh_ext = MW'(prod[PW-1:8]);
  assign mx_new = (sh_ext > MW'({FB{1'b1}})) ? {FB{1'b1}} : sh_ext[FB-1:0];

  assign count_inc = count_q + IW'(1);

  assign rd_cur  = slot_rdata[FB-1:0];
  assign rd_max  = slot_rdata[O_MX +: FB];
  assign rd_rep  = slot_rdata[O_RP];
  assign rd_ar   = slot_rdata[O_AR];
  assign rd_hdl  = slot_rdata[O_HD +: IW];
  assign rd_done = (rd_max <= rd_cur);

  always_comb begin
    sts_o.add_ok    = (dur_q != '0) && ((CW'(count_q) + CW'(1)) < CW'(ENTRIES))
                      && (hint_q != '0) && (CW'(hint_q) < CW'(ENTRIES));
    sts_o.hint_free = !hlive_q[hint_q];
    sts_o.scan_end  = (scan_q == CW'(ENTRIES));
    sts_o.scan_free = !hlive_q[scan_q[IW-1:0]];
    sts_o.hit       = (hdl_q != '0) && (CW'(hdl_q) < CW'(ENTRIES)) && hlive_q[hdl_q];
    sts_o.drop_move = (s_q < count_q);
    sts_o.tick_more = (idx_q <= CW'(count_q));
    sts_o.tick_drop = rd_done && !rd_rep && rd_ar;
    sts_o.out_free  = !ov_q || out_ready_i;
  end

  // memory port steering
  always_comb begin
    h2s_we    = cmd_i.add_write || cmd_i.move_write;
    h2s_waddr = cmd_i.add_write ? hsel_q : rd_hdl;
    h2s_wdata = cmd_i.add_write ? count_inc : s_q;
    h2s_re    = cmd_i.h2s_rd;

    slot_re = cmd_i.lk_slot_rd || cmd_i.last_rd || cmd_i.tick_rd;
    if (cmd_i.lk_slot_rd) begin
      slot_raddr = h2s_rdata;
    end else if (cmd_i.last_rd) begin
      slot_raddr = count_q;
    end else begin
      slot_raddr = idx_q[IW-1:0];
    end

    slot_we    = 1'b0;
    slot_waddr = idx_q[IW-1:0];
    slot_wdata = slot_rdata;
    if (cmd_i.add_write) begin
      slot_we    = 1'b1;
      slot_waddr = count_inc;
      slot_wdata = {hsel_q, ar_q, rep_q, mx_q, {FB{1'b0}}};
    end else if (cmd_i.move_write) begin
      slot_we    = 1'b1;
      slot_waddr = s_q;
    end else if (cmd_i.tick_upd) begin
      slot_we    = !(rd_done && !rd_rep);
      slot_wdata = {rd_hdl, rd_ar, rd_rep, rd_max,
                    rd_done ? {FB{1'b0}} : (rd_cur + FB'(1))};
    end
  end

  ftht_ram #(
    .WIDTH (IW),
    .DEPTH (ENTRIES)
  ) u_h2s_ram (
    .clk_i   (clk_i),
    .we_i    (h2s_we),
    .waddr_i (h2s_waddr),
    .wdata_i (h2s_wdata),
    .re_i    (h2s_re),
    .raddr_i (hdl_q),
    .rdata_o (h2s_rdata)
  );

  ftht_ram #(
    .WIDTH (SW),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // request capture and scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      dur_q <= in_duration_i;
      mx_q  <= mx_new;
      rep_q <= in_repeat_i;
      ar_q  <= in_remove_i;
      hdl_q <= in_handle_i;
    end
    if (cmd_i.take_hint) begin
      hsel_q <= hint_q;
    end else if (cmd_i.take_scan) begin
      hsel_q <= scan_q[IW-1:0];
    end
    if (cmd_i.scan_init) begin
      scan_q <= CW'(hint_q) + CW'(1);
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + CW'(1);
    end
    if (cmd_i.drop_from_h2s) begin
      s_q  <= h2s_rdata;
      dh_q <= hdl_q;
    end else if (cmd_i.drop_from_tick) begin
      s_q  <= idx_q[IW-1:0];
      dh_q <= rd_hdl;
    end
    if (cmd_i.cap_in) begin
      idx_q <= CW'(1);
    end else if (cmd_i.tick_adv) begin
      idx_q <= idx_q + CW'(1);
    end
    if (cmd_i.cap_in) begin
      nh_q  <= '0;
      cur_q <= '0;
      max_q <= '0;
      fnd_q <= 1'b0;
    end else if (cmd_i.add_write) begin
      nh_q <= hsel_q;
    end else if (cmd_i.lk_cap) begin
      cur_q <= rd_cur;
      max_q <= rd_max;
      fnd_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      onh_q   <= nh_q;
      ocur_q  <= cur_q;
      omax_q  <= max_q;
      ofnd_q  <= fnd_q;
      olive_q <= count_q;
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q   <= ftht_pkg::FPS_RESET;
      count_q <= '0;
      hint_q  <= IW'(1);
      hlive_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        fps_q <= cfg_wr_data_i;
      end
      if (cmd_i.add_write) begin
        count_q         <= count_inc;
        hlive_q[hsel_q] <= 1'b1;
      end else if (cmd_i.drop_fin) begin
        count_q       <= count_q - IW'(1);
        hlive_q[dh_q] <= 1'b0;
      end
      if (cmd_i.take_scan) begin
        hint_q <= hint_q + IW'(1);
      end else if (cmd_i.drop_fin && (hint_q > dh_q)) begin
        hint_q <= dh_q;
      end
      if (cmd_i.load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign out_new_handle_o = onh_q;
  assign out_current_o    = ocur_q;
  assign out_max_o        = omax_q;
  assign out_found_o      = ofnd_q;
  assign out_live_o       = olive_q;

endmodule

// ----- rtl/frame_timer_handle_table_unit.sv -----
// ----------------------------------------------------------------------------
// frame_timer_handle_table_unit
// handle addressed table of frame counters with add, remove, lookup and tick
// ----------------------------------------------------------------------------
// one request at a time; the result sits in an output register so the next
// request is taken while it waits. a lookup reads the handle map and then
// the slot ram; a remove answers on a miss and on a hit moves the last slot
// into the freed one unless the freed slot is the last. an add is rejected,
// takes the hinted handle when it is free, or else scans the handles above
// the hint (up to ENTRIES) for a free one. a tick walks every live entry,
// and an entry that frees itself goes through the same drop steps as a remove.
// no clearing pass after reset.
module frame_timer_handle_table_unit #(
  parameter int unsigned ENTRIES    = ftht_pkg::ENTRIES_DEF,
  parameter int unsigned FRAME_BITS = ftht_pkg::FRAME_BITS_DEF,
  localparam int unsigned IW    = $clog2(ENTRIES),
  localparam int unsigned IN_W  = ftht_pkg::DUR_W + 2 + IW,
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = 2 * IW + 2 * FRAME_BITS + 1,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [ftht_pkg::FPS_W-1:0] cfg_wr_data_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // duration, repeat_mode, remove_when_done, handle
  input  logic [IN_TW-1:0]           s_axis_tdata_i,
  // op
  input  logic [ftht_pkg::OP_W-1:0]  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // new_handle, current_frame, max_frame, found, live_count
  output logic [OUT_TW-1:0]          m_axis_tdata_o
);

  `include "frame_timer_handle_table_unit_assert.svh"

  localparam int unsigned DW = ftht_pkg::DUR_W;

  ftht_pkg::cmd_t        cmd;
  ftht_pkg::sts_t        sts;
  logic [IW-1:0]         out_nh, out_live;
  logic [FRAME_BITS-1:0] out_cur, out_max;
  logic                  out_fnd;

  ftht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftht_dp #(
    .ENTRIES    (ENTRIES),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_duration_i    (s_axis_tdata_i[DW-1:0]),
    .in_repeat_i      (s_axis_tdata_i[DW]),
    .in_remove_i      (s_axis_tdata_i[DW+1]),
    .in_handle_i      (s_axis_tdata_i[DW+2 +: IW]),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_new_handle_o (out_nh),
    .out_current_o    (out_cur),
    .out_max_o        (out_max),
    .out_found_o      (out_fnd),
    .out_live_o       (out_live)
  );

  assign m_axis_tdata_o = OUT_TW'({out_live, out_fnd, out_max, out_cur, out_nh});

  `FTHT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `FTHT_ASSERT_IMPLY(a_result_frees_input, clk_i, rst_ni, $rose(m_axis_tvalid_o), s_axis_tready_o)
  `FTHT_ASSERT_IMPLY(a_found_no_handle, clk_i, rst_ni, m_axis_tvalid_o && out_fnd, out_nh == '0)

endmodule

// ----- sim/frame_timer_handle_table_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_timer_handle_table_unit_test
// drives add, remove, lookup and tick requests under several frame rates and
// idle patterns, predicts every result in a scoreboard and compares by field
// ----------------------------------------------------------------------------
module frame_timer_handle_table_unit_test;

  localparam int unsigned NE = 64;
  localparam int unsigned IN_TW = 24;
  localparam int unsigned OUT_TW = 48;
  localparam int unsigned LIMIT = 3000000;

  typedef struct packed {
    logic [5:0]  new_handle;
    logic [15:0] cur;
    logic [15:0] max;
    logic        found;
    logic [5:0]  live;
  } result_t;

  class timer_scoreboard;
    logic [5:0]  h2s [NE];
    logic [15:0] s_cur [NE];
    logic [15:0] s_max [NE];
    logic        s_rep [NE];
    logic        s_arm [NE];
    logic [5:0]  s_hdl [NE];
    int unsigned count;
    int unsigned hint;
    logic [7:0]  fps;
    result_t     pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      for (int i = 0; i < NE; i++) begin
        h2s[i] = 0; s_cur[i] = 0; s_max[i] = 0; s_rep[i] = 0; s_arm[i] = 0; s_hdl[i] = 0;
      end
      count = 0; hint = 1; fps = ftht_pkg::FPS_RESET; errors = 0; checked = 0;
    endfunction

    function void drop(int unsigned h);
      int unsigned s;
      s = (h == 0 || h >= NE) ? 0 : h2s[h];
      if (s == 0 || count == 0) return;
      if (s < count) begin
        s_cur[s] = s_cur[count]; s_max[s] = s_max[count];
        s_rep[s] = s_rep[count]; s_arm[s] = s_arm[count];
        s_hdl[s] = s_hdl[count]; h2s[s_hdl[s]] = 6'(s);
      end
      h2s[h] = 0;
      count--;
      if (hint > h) hint = h;
    endfunction

    function logic [5:0] add(logic [15:0] dur, logic rep, logic arm);
      int unsigned h, s;
      longint unsigned mx;
      h = 0;
      if (dur == 0 || count + 1 >= NE || hint == 0 || hint >= NE) return 0;
      if (h2s[hint] == 0) h = hint;
      else begin
        for (int i = hint; i < NE; i++)
          if (h2s[i] == 0) begin
            h = i; hint++; break;
          end
      end
      if (h == 0) return 0;
      s = count + 1;
      h2s[h] = 6'(s);
      mx = (longint'(dur) * fps) >> 8;
      if (mx > 65535) mx = 65535;
      s_cur[s] = 0; s_max[s] = 16'(mx); s_rep[s] = rep; s_arm[s] = arm; s_hdl[s] = 6'(h);
      count = s;
      return 6'(h);
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] dur, logic rep, logic arm,
                               logic [5:0] h);
      result_t r;
      int unsigned s;
      r = '0;
      case (op)
        ftht_pkg::OP_ADD: r.new_handle = add(dur, rep, arm);
        ftht_pkg::OP_REMOVE: drop(h);
        ftht_pkg::OP_LOOKUP: begin
          s = (h == 0) ? 0 : h2s[h];
          if (s != 0) begin
            r.cur = s_cur[s]; r.max = s_max[s]; r.found = 1'b1;
          end
        end
        default: begin
          for (int i = 1; i <= count && i < NE; i++) begin
            if (s_max[i] <= s_cur[i]) begin
              if (s_rep[i]) s_cur[i] = 0;
              else if (s_arm[i]) drop(s_hdl[i]);
            end else s_cur[i] = s_cur[i] + 16'd1;
          end
        end
      endcase
      r.live = 6'(count);
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TW-1:0] d);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[5:0] !== e.new_handle) begin
        $error("new_handle exp %0d got %0d", e.new_handle, d[5:0]); errors++;
      end
      if (d[21:6] !== e.cur) begin
        $error("current_frame exp %0d got %0d", e.cur, d[21:6]); errors++;
      end
      if (d[37:22] !== e.max) begin
        $error("max_frame exp %0d got %0d", e.max, d[37:22]); errors++;
      end
      if (d[38] !== e.found) begin
        $error("found exp %0d got %0d", e.found, d[38]); errors++;
      end
      if (d[44:39] !== e.live) begin
        $error("live_count exp %0d got %0d", e.live, d[44:39]); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_wr_en_i;
  logic [7:0] cfg_wr_data_i;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [IN_TW-1:0] s_axis_tdata_i;
  logic [1:0] s_axis_tuser_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [OUT_TW-1:0] m_axis_tdata_o;

  timer_scoreboard sb;
  int unsigned cycles;
  int unsigned send_idle, recv_stall;
  int unsigned requests;

  frame_timer_handle_table_unit i_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("cycle limit reached");
        $display("frame_timer_handle_table_unit test failed");
        $finish;
      end
    end
  end

  // result side: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  // valid stays high after accept until the next request or idle_input
  task automatic send(logic [1:0] op, logic [15:0] dur, logic rep, logic arm,
                      logic [5:0] h);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {h, arm, rep, dur};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, dur, rep, arm, h);
    requests++;
  endtask

  task automatic idle_input();
    s_axis_tvalid_i <= 0;
  endtask

  task automatic write_fps(logic [7:0] v);
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 0;
    sb.fps = v;
  endtask

  task automatic random_request();
    int unsigned k;
    logic [15:0] dur;
    logic [5:0] h;
    k = $urandom_range(99);
    h = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(sb.count + 3));
    dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    if ($urandom_range(29) == 0) dur = 0;
    if (k < 30) send(ftht_pkg::OP_ADD, dur, 1'($urandom), 1'($urandom), h);
    else if (k < 45) send(ftht_pkg::OP_REMOVE, dur, 1'($urandom), 1'($urandom), h);
    else if (k < 65) send(ftht_pkg::OP_LOOKUP, dur, 1'($urandom), 1'($urandom), h);
    else send(ftht_pkg::OP_TICK, dur, 1'($urandom), 1'($urandom), h);
  endtask

  initial begin
    sb = new();
    requests = 0;
    send_idle = 0; recv_stall = 0;
    rst_ni = 0;
    cfg_wr_en_i = 0; cfg_wr_data_i = 0;
    s_axis_tvalid_i = 0; s_axis_tdata_i = 0; s_axis_tuser_i = 0;
    m_axis_tready_i = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: zero duration, extremes, misses, self removal
    send(ftht_pkg::OP_ADD, 16'd0, 0, 0, 0);
    send(ftht_pkg::OP_ADD, 16'hffff, 1, 1, 6'h3f);
    send(ftht_pkg::OP_ADD, 16'd5, 0, 1, 0);
    send(ftht_pkg::OP_ADD, 16'd9, 0, 0, 0);
    send(ftht_pkg::OP_ADD, 16'd3, 1, 0, 0);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd0);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd63);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd2);
    repeat (3) send(ftht_pkg::OP_TICK, 0, 0, 0, 0);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd2);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd3);
    send(ftht_pkg::OP_REMOVE, 0, 0, 0, 6'd0);
    send(ftht_pkg::OP_REMOVE, 0, 0, 0, 6'd40);
    send(ftht_pkg::OP_REMOVE, 0, 0, 0, 6'd1);
    send(ftht_pkg::OP_ADD, 16'd1, 0, 0, 0);
    write_fps(8'd0);
    send(ftht_pkg::OP_ADD, 16'd100, 1, 0, 0);
    send(ftht_pkg::OP_TICK, 0, 0, 0, 0);
    write_fps(8'd255);
    send(ftht_pkg::OP_ADD, 16'hffff, 0, 0, 0);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd4);

    // fill the table to full and beyond
    write_fps(8'd1);
    repeat (66) send(ftht_pkg::OP_ADD, 16'($urandom_range(1, 2000)), 1'($urandom),
                     1'($urandom), 0);
    send(ftht_pkg::OP_LOOKUP, 0, 0, 0, 6'd63);
    repeat (30) send(ftht_pkg::OP_REMOVE, 0, 0, 0, 6'($urandom_range(1, 63)));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 66; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 66; end
        default: begin send_idle = 6; recv_stall = 6; end
      endcase
      write_fps((ph == 3) ? 8'd240 : (ph == 6) ? 8'd1 : 8'($urandom_range(1, 240)));
      repeat (250) random_request();
    end

    idle_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked over 8 frame rate phases",
             requests, sb.checked);
    if (sb.errors == 0) $display("frame_timer_handle_table_unit test passed");
    else $display("frame_timer_handle_table_unit test failed");
    $finish;
  end
endmodule
